// File: design/bba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap block allocator.
// Used by the interfaces, the controller, the datapath and the checker.
package bba_pkg;

    // Field widths of the request, response and configuration register.
    localparam int OP_W    = 1;
    localparam int IDX_W   = 10;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 11;
    localparam int TOTAL_W = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;
    localparam logic [7:0]         FULL_BYTE   = 8'hFF;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_req;
        logic    ptr_clear;
        logic    clr_write;
        logic    scan_step;
        logic    free_read;
        logic    wd_load;
        logic    res_load;
        status_t res_code;
        logic    bm_write;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op;
        logic count_full;
        logic idx_invalid;
        logic clr_last;
        logic pend;
        logic hit;
        logic blk_ok;
        logic scan_none;
        logic bit_set;
        logic out_busy;
    } sts_t;

    // Position of the lowest clear bit of a byte (only used when one exists).
    function automatic logic [2:0] lowest_clear(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (!v[b])
            begin
                pos = 3'(b);
            end
        end
        return pos;
    endfunction

endpackage

// File: design/bba_req_if.sv
`timescale 1ns / 1ps
// Request channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output op, output block_index, input ready);
    modport sink   (input valid, input op, input block_index, output ready);
endinterface

// File: design/bba_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted_block;
    logic [CNT_W-1:0] allocated_count;

    modport source (output valid, output status, output granted_block,
                    output allocated_count, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input allocated_count, output ready);
endinterface

// File: design/bba_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: design/bba_ctrl.sv
`timescale 1ns / 1ps
// Controller of the bitmap block allocator: sequences the clearing pass,
// the first-fit scan and the free path. Depends on bba_pkg.
module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE_CHK,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (sts.op == OP_ALLOC)
                begin
                    if (sts.count_full)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_NO_FREE;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (sts.idx_invalid)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_INVALID;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_CHK;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.pend && sts.hit)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.blk_ok)
                    begin
                        cmd.res_code = ST_OK;
                        cmd.wd_load  = 1'b1;
                        state_next   = S_WRITE;
                    end
                    else
                    begin
                        cmd.res_code = ST_NO_FREE;
                        state_next   = S_FINISH;
                    end
                end
                else if (sts.scan_none)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_NO_FREE;
                    state_next   = S_FINISH;
                end
            end
            S_FREE_CHK:
            begin
                cmd.res_load = 1'b1;
                if (sts.bit_set)
                begin
                    cmd.res_code = ST_OK;
                    cmd.wd_load  = 1'b1;
                    state_next   = S_WRITE;
                end
                else
                begin
                    cmd.res_code = ST_NOT_ALLOC;
                    state_next   = S_FINISH;
                end
            end
            S_WRITE:
            begin
                cmd.bm_write = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;
endmodule

// File: design/bba_datapath.sv
`timescale 1ns / 1ps
// Datapath of the bitmap block allocator: bitmap RAM, block count, scan
// pointer, result and output registers. Depends on bba_pkg and bba_ram.
module bba_datapath #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::TOTAL_W-1:0]   cfg_wdata,
    input  logic [bba_pkg::OP_W-1:0]      in_op,
    input  logic [bba_pkg::IDX_W-1:0]     in_block_index,
    input  bba_pkg::cmd_t                 cmd,
    output bba_pkg::sts_t                 sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [bba_pkg::ST_W-1:0]      out_status,
    output logic [bba_pkg::IDX_W-1:0]     out_granted_block,
    output logic [bba_pkg::CNT_W-1:0]     out_allocated_count
);
    import bba_pkg::*;

    localparam int BYTES = (MAX_BLOCKS + 7) / 8;
    localparam int AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int PW    = $clog2(BYTES + 1);
    localparam int TW    = $clog2(MAX_BLOCKS + 1);
    localparam int CW0   = (TW > TOTAL_W) ? TW : TOTAL_W;
    localparam int CW    = (PW + 3 > CW0) ? PW + 3 : CW0;

    logic [TOTAL_W-1:0] total_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PW-1:0]      ptr_reg;
    logic               pend_reg;
    logic [AW-1:0]      chk_byte_reg;
    logic [7:0]         wdata_reg;
    status_t            res_status_reg;
    logic [IDX_W-1:0]   res_granted_reg;
    logic               out_valid_reg;
    logic [ST_W-1:0]    out_status_reg;
    logic [IDX_W-1:0]   out_granted_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic [CW-1:0]   total_ext;
    logic [CW-1:0]   etotal;
    logic [CW-1:0]   idx_ext;
    logic            in_range;
    logic [7:0]      rd_data;
    logic [2:0]      low_bit;
    logic [2:0]      free_bit;
    logic [AW+2:0]   blk;
    logic            hit;
    logic            issue;
    logic [AW-1:0]   free_byte;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;

    // Effective block total, capped at the bitmap size.
    assign total_ext = CW'(total_reg);
    assign etotal    = (total_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : total_ext;
    assign idx_ext   = CW'(idx_reg);

    // Scan pointer range: inside the bitmap and below the block total.
    assign in_range = (ptr_reg < PW'(BYTES)) && (CW'({ptr_reg, 3'b000}) < etotal);

    // Candidate block from the byte just read.
    assign low_bit   = lowest_clear(rd_data);
    assign blk       = {chk_byte_reg, low_bit};
    assign hit       = (rd_data != FULL_BYTE);
    assign free_byte = idx_ext[AW+2:3];
    assign free_bit  = idx_reg[2:0];

    // A read is issued while scanning unless the current byte already hits.
    assign issue = cmd.scan_step && in_range && !(pend_reg && hit);

    // RAM port selection.
    assign ram_re    = issue || cmd.free_read;
    assign ram_raddr = cmd.free_read ? free_byte : ptr_reg[AW-1:0];
    assign ram_we    = cmd.clr_write || cmd.bm_write;
    assign ram_waddr = cmd.clr_write ? ptr_reg[AW-1:0] : chk_byte_reg;
    assign ram_wdata = cmd.clr_write ? 8'h00 : wdata_reg;

    bba_ram #(
        .WIDTH (8),
        .DEPTH (BYTES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Configuration register, block count and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            used_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (cmd.bm_write)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
                else if (used_reg != '0)
                begin
                    used_reg <= used_reg - CNT_W'(1);
                end
            end
            if (cmd.ptr_clear)
            begin
                ptr_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clr_write || issue)
                begin
                    ptr_reg <= ptr_reg + PW'(1);
                end
                if (cmd.scan_step)
                begin
                    pend_reg <= issue;
                end
            end
        end
    end

    // Request, checked byte, new byte value and pending result.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            op_reg  <= in_op;
            idx_reg <= in_block_index;
        end
        if (issue)
        begin
            chk_byte_reg <= ptr_reg[AW-1:0];
        end
        else if (cmd.free_read)
        begin
            chk_byte_reg <= free_byte;
        end
        if (cmd.wd_load)
        begin
            if (op_reg == OP_FREE)
            begin
                wdata_reg <= rd_data & ~(8'b1 << free_bit);
            end
            else
            begin
                wdata_reg <= rd_data | (8'b1 << low_bit);
            end
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == ST_OK && op_reg == OP_ALLOC)
            begin
                res_granted_reg <= IDX_W'(blk);
            end
            else
            begin
                res_granted_reg <= '0;
            end
        end
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_count_reg   <= used_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.op          = op_reg;
        sts.count_full  = (CW'(used_reg) >= etotal);
        sts.idx_invalid = (idx_ext >= etotal);
        sts.clr_last    = (ptr_reg == PW'(BYTES - 1));
        sts.pend        = pend_reg;
        sts.hit         = hit;
        sts.blk_ok      = (CW'(blk) < etotal);
        sts.scan_none   = !pend_reg && !in_range;
        sts.bit_set     = rd_data[free_bit];
        sts.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid           = out_valid_reg;
    assign out_status          = out_status_reg;
    assign out_granted_block   = out_granted_reg;
    assign out_allocated_count = out_count_reg;
endmodule

// File: design/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Channel    Dir   Fields                                       Handshake
// req        in    op, block_index                              valid/ready
// rsp        out   status, granted_block, allocated_count       valid/ready
// cfg        in    cfg_wdata (block_total)                      cfg_we
//
// A request passes the start and finish states; between them a free reads its bitmap byte
// and an allocate scans the bitmap bytes, one per cycle from the RAM read port; a
// granted request writes its byte back. Finish waits while the output is stalled.
// After reset a clearing pass zeroes the bitmap RAM with req.ready low; configuration
// writes are taken during it. A finished item waits in the output register while the
// next one is taken.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bba_pkg::TOTAL_W-1:0] cfg_wdata,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp
);
    import bba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Bitmap storage and arithmetic.
    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_op               (req.op),
        .in_block_index      (req.block_index),
        .cmd                 (cmd),
        .sts                 (sts),
        .out_ready           (rsp.ready),
        .out_valid           (rsp.valid),
        .out_status          (rsp.status),
        .out_granted_block   (rsp.granted_block),
        .out_allocated_count (rsp.allocated_count)
    );
endmodule

// File: design/bba_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [bba_pkg::ST_W-1:0]  rsp_status,
    input logic [bba_pkg::IDX_W-1:0] rsp_granted_block,
    input logic [bba_pkg::CNT_W-1:0] rsp_allocated_count
);
    import bba_pkg::*;

    // A stalled response keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_granted_block) && $stable(rsp_allocated_count))
        else $error("response changed while stalled");

    // Only a granted allocate carries a block number.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_granted_block == '0)
        else $error("nonzero block on a refused request");

    // One request in flight: ready drops right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while one is in flight");
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_granted_block   (rsp.granted_block),
    .rsp_allocated_count (rsp.allocated_count)
);

// File: tb/sv/tb_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap block allocator: a directed table, then random phases.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bitmap_block_allocator.
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int NUM_BLOCKS        = 1024;
    localparam int BITMAP_BYTES      = NUM_BLOCKS / 8;
    localparam int IDLE_CYCLE_LIMIT  = 5000;
    localparam int DRAIN_CYCLES      = 150;
    localparam int MAX_REPORTS       = 200;
    localparam int NUM_DIRECTED      = 26;
    localparam int NUM_PHASES        = 9;
    localparam int RANDOM_TOTAL      = -1;

    // One expected response of the allocator.
    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] count;
    } alloc_result_t;

    // One row of the directed table: either a register write or a request.
    typedef struct packed {
        logic               is_cfg;
        logic               op;
        logic [IDX_W-1:0]   block_index;
        logic [TOTAL_W-1:0] total;
        logic               has_known;
        status_t            status;
        logic [IDX_W-1:0]   granted;
        logic [CNT_W-1:0]   count;
    } directed_row_t;

    // One random phase: block total, request count, allocate share, idling and stalling.
    typedef struct packed {
        int total;
        int items;
        int alloc_pct;
        int idle_pct;
        int stall_pct;
    } phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TOTAL_W-1:0] cfg_wdata;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow state of the allocator.
    logic [7:0]         shadow_bitmap [BITMAP_BYTES];
    logic [CNT_W-1:0]   shadow_count;
    logic [TOTAL_W-1:0] shadow_total;
    int                 held_blocks [$];
    alloc_result_t      pending_results [$];

    int mismatch_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    // The directed rows: reset state, both operations, and the special totals.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // Fresh allocator: first fit from block zero, free checks.
        '{1'b0, OP_ALLOC, 10'h3FF, 11'd0, 1'b1, ST_OK,        10'd0, 11'd1},
        '{1'b0, OP_ALLOC, 10'h000, 11'd0, 1'b1, ST_OK,        10'd1, 11'd2},
        '{1'b0, OP_FREE,  10'h3FF, 11'd0, 1'b1, ST_NOT_ALLOC, 10'd0, 11'd2},
        '{1'b0, OP_FREE,  10'h000, 11'd0, 1'b1, ST_OK,        10'd0, 11'd1},
        '{1'b0, OP_ALLOC, 10'h155, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h001, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h001, 11'd0, 1'b1, ST_NOT_ALLOC, 10'd0, 11'd1},
        // A total of zero refuses everything.
        '{1'b1, OP_ALLOC, 10'h000, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_ALLOC, 10'h2AA, 11'd0, 1'b1, ST_NO_FREE,   10'd0, 11'd1},
        '{1'b0, OP_FREE,  10'h000, 11'd0, 1'b1, ST_INVALID,   10'd0, 11'd1},
        // A total above the block count behaves as the block count.
        '{1'b1, OP_ALLOC, 10'h000, 11'd2047, 1'b0, ST_OK,     10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h3FF, 11'd0, 1'b1, ST_NOT_ALLOC, 10'd0, 11'd1},
        '{1'b0, OP_ALLOC, 10'h000, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_ALLOC, 10'h3FF, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        // A total lowered below the count: blocks above it stay counted.
        '{1'b1, OP_ALLOC, 10'h000, 11'd1, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_ALLOC, 10'h000, 11'd0, 1'b1, ST_NO_FREE,   10'd0, 11'd3},
        '{1'b0, OP_FREE,  10'h002, 11'd0, 1'b1, ST_INVALID,   10'd0, 11'd3},
        '{1'b0, OP_FREE,  10'h000, 11'd0, 1'b1, ST_OK,        10'd0, 11'd2},
        '{1'b0, OP_ALLOC, 10'h000, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        // Back to the full volume.
        '{1'b1, OP_ALLOC, 10'h000, 11'd1024, 1'b0, ST_OK,     10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h002, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h001, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_ALLOC, 10'h000, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h200, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h155, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0},
        '{1'b0, OP_FREE,  10'h2AA, 11'd0, 1'b0, ST_OK,        10'd0, 11'd0}
    };

    // Random phases; the second one fills a 160-block volume and runs into refusals.
    phase_t phases [NUM_PHASES] = '{
        '{16,           40,   60, 0,  0},
        '{160,          170,  100, 0, 0},
        '{1024,         60,   25, 87, 0},
        '{37,           50,   55, 0,  87},
        '{2047,         50,   50, 12, 12},
        '{0,            10,   50, 87, 0},
        '{5,            30,   60, 0,  87},
        '{RANDOM_TOTAL, 40,   50, 12, 12},
        '{1024,         24,   40, 0,  0}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Works out the response to one request and updates the shadow state.
    function automatic alloc_result_t predict_request(logic op, logic [IDX_W-1:0] blk_idx);
        alloc_result_t r;
        int total;
        int pick;
        int pos;
        int i;
        int k;
        total = (shadow_total > NUM_BLOCKS) ? NUM_BLOCKS : int'(shadow_total);
        r.status = ST_OK;
        r.granted = '0;
        if (op == OP_ALLOC)
        begin
            if (shadow_count >= total)
            begin
                r.status = ST_NO_FREE;
            end
            else
            begin
                // The first byte with a clear bit decides, even if that bit is past the total.
                pick = -1;
                for (i = 0; i < BITMAP_BYTES; i++)
                begin
                    if (pick < 0 && i * 8 < total && shadow_bitmap[i] != FULL_BYTE)
                    begin
                        pos = 0;
                        while (shadow_bitmap[i][pos])
                        begin
                            pos++;
                        end
                        pick = i * 8 + pos;
                    end
                end
                if (pick >= 0 && pick < total)
                begin
                    shadow_bitmap[pick / 8][pick % 8] = 1'b1;
                    shadow_count = shadow_count + 1'b1;
                    r.granted = pick[IDX_W-1:0];
                    held_blocks.push_back(pick);
                end
                else
                begin
                    r.status = ST_NO_FREE;
                end
            end
        end
        else
        begin
            if (blk_idx >= total)
            begin
                r.status = ST_INVALID;
            end
            else if (!shadow_bitmap[blk_idx / 8][blk_idx % 8])
            begin
                r.status = ST_NOT_ALLOC;
            end
            else
            begin
                shadow_bitmap[blk_idx / 8][blk_idx % 8] = 1'b0;
                if (shadow_count > 0)
                begin
                    shadow_count = shadow_count - 1'b1;
                end
                for (k = 0; k < held_blocks.size(); k++)
                begin
                    if (held_blocks[k] == blk_idx)
                    begin
                        held_blocks.delete(k);
                        break;
                    end
                end
            end
        end
        r.count = shadow_count;
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records the expected response.
    task automatic send_request(logic op, logic [IDX_W-1:0] blk_idx, logic has_known,
                                alloc_result_t known);
        alloc_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.block_index <= blk_idx;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        r = predict_request(op, blk_idx);
        if (has_known)
        begin
            r = known;
        end
        pending_results.push_back(r);
    endtask

    // Writes the block total once every outstanding response has come back.
    task automatic write_block_total(logic [TOTAL_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_total = value;
    endtask

    // Stimulus: reset, directed table, random phases, drain, verdict.
    initial
    begin
        alloc_result_t known;
        alloc_result_t unused;
        logic op;
        logic [IDX_W-1:0] blk_idx;
        int total;

        unused = '0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_ALLOC;
        req_ch.block_index <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        for (int i = 0; i < BITMAP_BYTES; i++)
        begin
            shadow_bitmap[i] = 8'h00;
        end
        shadow_count = '0;
        shadow_total = TOTAL_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        idle_pct  = 0;
        stall_pct = 0;
        foreach (directed_rows[n])
        begin
            if (directed_rows[n].is_cfg)
            begin
                write_block_total(directed_rows[n].total);
            end
            else
            begin
                known.status  = directed_rows[n].status;
                known.granted = directed_rows[n].granted;
                known.count   = directed_rows[n].count;
                send_request(directed_rows[n].op, directed_rows[n].block_index,
                             directed_rows[n].has_known, known);
            end
        end

        // Random phases: mostly allocates and frees of held blocks, some stray frees.
        foreach (phases[p])
        begin
            total = (phases[p].total == RANDOM_TOTAL) ? $urandom_range(2047) : phases[p].total;
            write_block_total(total[TOTAL_W-1:0]);
            idle_pct  = phases[p].idle_pct;
            stall_pct = phases[p].stall_pct;
            for (int n = 0; n < phases[p].items; n++)
            begin
                blk_idx = IDX_W'($urandom_range(NUM_BLOCKS - 1));
                if ($urandom_range(99) < phases[p].alloc_pct)
                begin
                    op = OP_ALLOC;
                end
                else
                begin
                    op = OP_FREE;
                    if (held_blocks.size() > 0 && $urandom_range(4) != 0)
                    begin
                        blk_idx = IDX_W'(held_blocks[$urandom_range(held_blocks.size() - 1)]);
                    end
                end
                send_request(op, blk_idx, 1'b0, unused);
            end
        end

        // Drain the outstanding responses, then give the block time to misbehave.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Response side: random stalls, and each taken item checked against the oldest expectation.
    initial
    begin
        alloc_result_t want;
        forever
        begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $error("response with no request outstanding");
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status != want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $error("status: expected %0d, actual %0d",
                                   want.status, rsp_ch.status);
                        end
                    end
                    if (rsp_ch.granted_block != want.granted)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $error("granted_block: expected %0d, actual %0d",
                                   want.granted, rsp_ch.granted_block);
                        end
                    end
                    if (rsp_ch.allocated_count != want.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $error("allocated_count: expected %0d, actual %0d",
                                   want.count, rsp_ch.allocated_count);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
design/bba_pkg.sv
design/bba_req_if.sv
design/bba_rsp_if.sv
design/bba_ram.sv
design/bba_ctrl.sv
design/bba_datapath.sv
design/bitmap_block_allocator.sv
design/bba_checker.sv
tb/sv/tb_bitmap_block_allocator.sv
